[design/tseb_pkg.sv]
`default_nettype none
package tseb_pkg;

	localparam int DEPTH     = 16;
	localparam int TIME_W    = 32;
	localparam int PAYLOAD_W = 32;
	localparam int IDX_W     = 4;
	localparam int CNT_W     = 5;
	localparam int KIND_W    = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ_IDX = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEAREST  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

	// decoded operation; all flags low means the word does nothing
	typedef struct packed {
		logic is_insert;
		logic is_read_idx;
		logic is_nearest;
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [TIME_W-1:0]    t;
		logic [PAYLOAD_W-1:0] pl;
		logic [IDX_W-1:0]     idx;
	} cmd_t;

endpackage
`default_nettype wire

[design/tseb_req_if.sv]
`default_nettype none
interface tseb_req_if import tseb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [TIME_W-1:0]    time_req;
	logic [PAYLOAD_W-1:0] payload;
	logic [IDX_W-1:0]     index;

	modport source (output valid, kind, time_req, payload, index, input ready);
	modport sink   (input valid, kind, time_req, payload, index, output ready);
endinterface
`default_nettype wire

[design/tseb_rsp_if.sv]
`default_nettype none
interface tseb_rsp_if import tseb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 found;
	logic [TIME_W-1:0]    entry_time;
	logic [PAYLOAD_W-1:0] entry_payload;
	logic [CNT_W-1:0]     count;
	logic                 rejected;

	modport source (output valid, found, entry_time, entry_payload, count, rejected,
		input ready);
	modport sink   (input valid, found, entry_time, entry_payload, count, rejected,
		output ready);
endinterface
`default_nettype wire

[design/time_sorted_event_buffer.sv]
// A word accepted into the input queue goes through the compare pass into the stage-1
// registers and is committed into the result registers once the output is free.
// A new word enters the compare pass over the cell array only after the commit pass
// (insert shift or read select) on the same cells has finished for the last word.
// Reset clears the fill count, the input queue and the output valid; cell contents
// are not reset and are only read below the fill count.
`default_nettype none
module time_sorted_event_buffer import tseb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tseb_req_if.sink   req,
	tseb_rsp_if.source rsp
);

	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;

	tseb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cmd   (q_cmd)
	);

	tseb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cmd   (q_cmd),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire

[design/tseb_front.sv]
`default_nettype none
module tseb_front import tseb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	tseb_req_if.sink   req,
	output logic       q_valid,
	input  logic       q_ready,
	output cmd_t       q_cmd
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       cmd_in;
	logic       push;
	logic       pop;

	always_comb begin
		cmd_in.op  = '0;
		cmd_in.t   = req.time_req;
		cmd_in.pl  = req.payload;
		cmd_in.idx = req.index;
		case (req.kind)
			KIND_INSERT:   cmd_in.op.is_insert   = 1'b1;
			KIND_READ_IDX: cmd_in.op.is_read_idx = 1'b1;
			KIND_NEAREST:  cmd_in.op.is_nearest  = 1'b1;
			KIND_NONE:     cmd_in.op             = '0;
			default:       cmd_in.op             = '0;
		endcase
	end

	assign req.ready = (fill_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (fill_q != 2'd0);
	assign pop       = q_valid && q_ready;
	assign q_cmd     = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				fill_q <= fill_q + 2'd1;
			else if (pop && !push)
				fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= cmd_in;
	end

endmodule
`default_nettype wire

[design/tseb_back.sv]
`default_nettype none
module tseb_back import tseb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_ready,
	input  cmd_t       q_cmd,
	tseb_rsp_if.source rsp
);

	logic [CNT_W-1:0]     count_q;
	logic [TIME_W-1:0]    time_q    [DEPTH];
	logic [PAYLOAD_W-1:0] payload_q [DEPTH];
	logic                 phase_q;

	logic [DEPTH-1:0]     occ;
	logic [DEPTH-1:0]     lt;
	logic [DEPTH-1:0]     first_ge;
	logic [DEPTH-1:0]     last_lt;
	logic [DEPTH-1:0]     post_sel;
	logic [TIME_W-1:0]    post_t;
	logic [PAYLOAD_W-1:0] post_p;
	logic [TIME_W-1:0]    pre_t;
	logic [PAYLOAD_W-1:0] pre_p;
	logic [CNT_W-1:0]     pos;

	cmd_t                 cmd_s1;
	logic [CNT_W-1:0]     pos_s1;
	logic [TIME_W-1:0]    post_t_s1;
	logic [PAYLOAD_W-1:0] post_p_s1;
	logic [TIME_W-1:0]    pre_t_s1;
	logic [PAYLOAD_W-1:0] pre_p_s1;

	logic                 cmp_fire;
	logic                 commit;
	logic                 has_post;
	logic                 eq_hit;
	logic                 full;
	logic                 do_upd;
	logic                 do_add;
	logic [TIME_W-1:0]    d_pre;
	logic [TIME_W-1:0]    d_post;
	logic                 res_found;
	logic [TIME_W-1:0]    res_t;
	logic [PAYLOAD_W-1:0] res_p;
	logic                 res_rej;
	logic [CNT_W-1:0]     cnt_next;

	logic                 rsp_valid_q;
	logic                 found_q;
	logic [TIME_W-1:0]    entry_time_q;
	logic [PAYLOAD_W-1:0] entry_payload_q;
	logic [CNT_W-1:0]     count_out_q;
	logic                 rejected_q;

	// compare stage: every cell compares against the request time at once
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = CNT_W'(i) < count_q;
			lt[i]  = occ[i] && (time_q[i] < q_cmd.t);
		end
		// lt is a prefix since the cells are sorted
		first_ge = occ & ~lt & {lt[DEPTH-2:0], 1'b1};
		last_lt  = lt & ~{1'b0, lt[DEPTH-1:1]};
		pos      = CNT_W'($countones(lt));
		for (int i = 0; i < DEPTH; i++)
			post_sel[i] = q_cmd.op.is_read_idx ? (IDX_W'(i) == q_cmd.idx) : first_ge[i];
		post_t = '0;
		post_p = '0;
		pre_t  = '0;
		pre_p  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			post_t = post_t | ({TIME_W{post_sel[i]}} & time_q[i]);
			post_p = post_p | ({PAYLOAD_W{post_sel[i]}} & payload_q[i]);
			pre_t  = pre_t | ({TIME_W{last_lt[i]}} & time_q[i]);
			pre_p  = pre_p | ({PAYLOAD_W{last_lt[i]}} & payload_q[i]);
		end
	end

	assign q_ready  = !phase_q;
	assign cmp_fire = q_valid && q_ready;
	assign commit   = phase_q && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk) begin
		if (cmp_fire) begin
			cmd_s1    <= q_cmd;
			pos_s1    <= pos;
			post_t_s1 <= post_t;
			post_p_s1 <= post_p;
			pre_t_s1  <= pre_t;
			pre_p_s1  <= pre_p;
		end
	end

	// commit stage
	always_comb begin
		has_post  = pos_s1 < count_q;
		eq_hit    = has_post && (post_t_s1 == cmd_s1.t);
		full      = (count_q == CNT_W'(DEPTH));
		do_upd    = cmd_s1.op.is_insert && eq_hit;
		do_add    = cmd_s1.op.is_insert && !eq_hit && !full;
		d_pre     = cmd_s1.t - pre_t_s1;
		d_post    = post_t_s1 - cmd_s1.t;
		res_found = 1'b0;
		res_t     = '0;
		res_p     = '0;
		res_rej   = cmd_s1.op.is_insert && !eq_hit && full;
		cnt_next  = count_q + CNT_W'(do_add);
		if (cmd_s1.op.is_read_idx) begin
			if ({1'b0, cmd_s1.idx} < count_q) begin
				res_found = 1'b1;
				res_t     = post_t_s1;
				res_p     = post_p_s1;
			end
		end else if (cmd_s1.op.is_nearest && count_q != '0) begin
			res_found = 1'b1;
			// nothing at or after the time: last entry; ties go to the later one
			if (!has_post || (pos_s1 != '0 && d_pre < d_post)) begin
				res_t = pre_t_s1;
				res_p = pre_p_s1;
			end else begin
				res_t = post_t_s1;
				res_p = post_p_s1;
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (commit) begin
				if (do_upd && pos_s1 == CNT_W'(g))
					payload_q[g] <= cmd_s1.pl;
				if (do_add) begin
					if (pos_s1 == CNT_W'(g)) begin
						time_q[g]    <= cmd_s1.t;
						payload_q[g] <= cmd_s1.pl;
					end else if (g > 0 && pos_s1 < CNT_W'(g)) begin
						time_q[g]    <= time_q[(g > 0) ? g - 1 : 0];
						payload_q[g] <= payload_q[(g > 0) ? g - 1 : 0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			phase_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmp_fire)
				phase_q <= 1'b1;
			else if (commit)
				phase_q <= 1'b0;
			if (commit) begin
				count_q     <= cnt_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			found_q         <= res_found;
			entry_time_q    <= res_t;
			entry_payload_q <= res_p;
			count_out_q     <= cnt_next;
			rejected_q      <= res_rej;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.found         = found_q;
	assign rsp.entry_time    = entry_time_q;
	assign rsp.entry_payload = entry_payload_q;
	assign rsp.count         = count_out_q;
	assign rsp.rejected      = rejected_q;

endmodule
`default_nettype wire

[design/tseb_checker.sv]
`default_nettype none
module tseb_checker import tseb_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic                 found,
	input logic [TIME_W-1:0]    entry_time,
	input logic [PAYLOAD_W-1:0] entry_payload,
	input logic [CNT_W-1:0]     count,
	input logic                 rejected
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(entry_time)
			&& $stable(entry_payload) && $stable(count) && $stable(found))
		else $error("stalled result word changed");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> count <= CNT_W'(DEPTH))
		else $error("count beyond depth");

	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rejected |-> count == CNT_W'(DEPTH) && !found)
		else $error("reject without a full buffer");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> entry_time == '0 && entry_payload == '0)
		else $error("miss carries nonzero entry");

	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found |-> count != '0 && !rejected)
		else $error("hit on an empty buffer");

endmodule

bind time_sorted_event_buffer tseb_checker u_tseb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.found         (rsp.found),
	.entry_time    (rsp.entry_time),
	.entry_payload (rsp.entry_payload),
	.count         (rsp.count),
	.rejected      (rsp.rejected)
);
`default_nettype wire
